>>> hdl/kpev_pkg.sv
// ----------------------------------------------------------------------------
// kpev_pkg : shared types and constants for the keypad event register slave
// Bus opcodes, register map addresses, interrupt status bit and key count mask.
// ----------------------------------------------------------------------------
package kpev_pkg;

   typedef enum logic [1:0] {
      OP_START  = 2'd0,
      OP_WRITE  = 2'd1,
      OP_READ   = 2'd2,
      OP_INJECT = 2'd3
   } kpev_op_type;

   // register map
   localparam logic [7:0] REG_INT_STAT  = 8'h02;
   localparam logic [7:0] REG_KEY_COUNT = 8'h03;
   localparam logic [7:0] REG_KEY_EVENT = 8'h04;

   localparam logic [7:0] INT_KEY_PENDING = 8'h01;
   localparam logic [7:0] COUNT_MASK      = 8'h0F;

endpackage

>>> hdl/keypad_event_fifo_register_slave.sv
// ----------------------------------------------------------------------------
// keypad_event_fifo_register_slave : keypad controller bus slave with key FIFO
// Register file behind a write-set pointer, W1C interrupt status, and a
// circular key-event queue that feeds the key event register.
// ----------------------------------------------------------------------------
//
//  channel   ports                                       handshake
//  -------   -----------------------------------------   ---------------------
//  request   req_opcode req_write_byte req_key_code       start & !busy
//            req_key_pressed
//  response  rsp_read_byte rsp_irq_n rsp_key_dropped      rsp_strobe, 1 cycle
//
//  One item per clock: busy stays low, every accepted item updates state at
//  its accept edge and its response shows on the cycle right after.
//  The rate is set by the register-file memory: its read port is addressed
//  by the next pointer, so its read data is registered along with the pointer, with a bypass for a same-edge write.
//  Synchronous active-high reset clears pointer, flags, queue counters,
//  interrupt status and the per-entry valid bits (no clearing pass).
//  The receiver cannot stall; a response is lost if not taken that cycle.
//
module keypad_event_fifo_register_slave
   import kpev_pkg::*;
#(
   parameter int REGISTER_COUNT = 64,
   parameter int EVENT_DEPTH    = 10
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [1:0] req_opcode,
   input  logic [7:0] req_write_byte,
   input  logic [6:0] req_key_code,
   input  logic       req_key_pressed,
   output logic       rsp_strobe,
   output logic [7:0] rsp_read_byte,
   output logic       rsp_irq_n,
   output logic       rsp_key_dropped
);

   localparam int AW = (REGISTER_COUNT > 1) ? $clog2(REGISTER_COUNT) : 1;
   localparam int SW = $clog2(EVENT_DEPTH);
   localparam int CW = $clog2(EVENT_DEPTH + 1);
   localparam logic [8:0]    REG_LIMIT = 9'(REGISTER_COUNT);
   localparam logic [SW-1:0] SLOT_LAST = SW'(EVENT_DEPTH - 1);
   localparam logic [CW-1:0] COUNT_FULL = CW'(EVENT_DEPTH);

   // ---------------- state ----------------
   logic [7:0]    ptr_ff, ptr_in;
   logic          phase_ff, phase_in;
   logic [7:0]    int_stat_ff, int_stat_in;
   logic [CW-1:0] count_ff, count_in;
   logic [SW-1:0] rd_slot_ff, rd_slot_in;
   logic [SW-1:0] wr_slot_ff, wr_slot_in;
   logic [7:0]    evt_ff [EVENT_DEPTH];

   // register file memory, valid bits stand in for the zero reset
   logic [7:0]    reg_mem [REGISTER_COUNT];
   logic [REGISTER_COUNT-1:0] valid_ff;
   logic [7:0]    mem_rd_ff;
   logic          byp_ff;
   logic [7:0]    byp_data_ff;

   // response register
   logic          strobe_ff;
   logic [7:0]    rbyte_ff, rbyte_in;
   logic          irq_n_ff;
   logic          drop_ff, drop_in;

   logic          accept;
   logic          ptr_in_range, ptr_in_next_range;
   logic [AW-1:0] ptr_idx, ptr_idx_in;
   logic          mem_we;
   logic          push, pop;
   logic [7:0]    cur_byte;

   assign busy   = 1'b0;
   assign accept = start & ~busy;

   assign ptr_in_range      = ({1'b0, ptr_ff} < REG_LIMIT);
   assign ptr_in_next_range = ({1'b0, ptr_in} < REG_LIMIT);
   assign ptr_idx           = ptr_ff[AW-1:0];
   assign ptr_idx_in        = ptr_in[AW-1:0];

   // plain data write to the pointed register (INT_STAT is W1C instead)
   assign mem_we = accept && (req_opcode == OP_WRITE) && phase_ff
                   && (ptr_ff != REG_INT_STAT) && ptr_in_range;

   assign pop  = accept && (req_opcode == OP_READ) && (ptr_ff == REG_KEY_EVENT)
                 && (count_ff != '0);
   assign push = accept && (req_opcode == OP_INJECT) && (count_ff != COUNT_FULL);

   // current content of the pointed register: bypass, then valid-gated memory
   always_comb begin
      if (byp_ff) begin
         cur_byte = byp_data_ff;
      end else if (ptr_in_range && valid_ff[ptr_idx]) begin
         cur_byte = mem_rd_ff;
      end else begin
         cur_byte = 8'h00;
      end
   end

   always_comb begin
      ptr_in      = ptr_ff;
      phase_in    = phase_ff;
      int_stat_in = int_stat_ff;
      count_in    = count_ff;
      rd_slot_in  = rd_slot_ff;
      wr_slot_in  = wr_slot_ff;
      rbyte_in    = 8'h00;
      drop_in     = 1'b0;
      if (accept) begin
         unique case (req_opcode)
            OP_START: begin
               phase_in = 1'b0;
            end
            OP_WRITE: begin
               if (!phase_ff) begin
                  ptr_in   = req_write_byte;
                  phase_in = 1'b1;
               end else if (ptr_ff == REG_INT_STAT) begin
                  int_stat_in = int_stat_ff & ~req_write_byte;
               end
            end
            OP_READ: begin
               priority if (ptr_ff == REG_INT_STAT) begin
                  rbyte_in = int_stat_ff;
               end else if (ptr_ff == REG_KEY_COUNT) begin
                  rbyte_in = 8'(count_ff) & COUNT_MASK;
               end else if (ptr_ff == REG_KEY_EVENT) begin
                  if (pop) begin
                     rbyte_in   = evt_ff[rd_slot_ff];
                     rd_slot_in = (rd_slot_ff == SLOT_LAST) ? '0 : rd_slot_ff + 1'b1;
                     count_in   = count_ff - 1'b1;
                     if (count_in != '0) begin
                        int_stat_in = int_stat_ff | INT_KEY_PENDING;
                     end
                  end
               end else begin
                  rbyte_in = cur_byte;
               end
            end
            OP_INJECT: begin
               if (push) begin
                  wr_slot_in  = (wr_slot_ff == SLOT_LAST) ? '0 : wr_slot_ff + 1'b1;
                  count_in    = count_ff + 1'b1;
                  int_stat_in = int_stat_ff | INT_KEY_PENDING;
               end else begin
                  drop_in = 1'b1;
               end
            end
            default: begin
               drop_in = 1'b0;
            end
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff      <= '0;
         phase_ff    <= 1'b0;
         int_stat_ff <= '0;
         count_ff    <= '0;
         rd_slot_ff  <= '0;
         wr_slot_ff  <= '0;
         valid_ff    <= '0;
         byp_ff      <= 1'b0;
         strobe_ff   <= 1'b0;
      end else begin
         ptr_ff      <= ptr_in;
         phase_ff    <= phase_in;
         int_stat_ff <= int_stat_in;
         count_ff    <= count_in;
         rd_slot_ff  <= rd_slot_in;
         wr_slot_ff  <= wr_slot_in;
         if (mem_we) begin
            valid_ff[ptr_idx] <= 1'b1;
         end
         // write landing on the register the next pointer selects
         byp_ff    <= mem_we && ptr_in_next_range && (ptr_idx_in == ptr_idx);
         strobe_ff <= accept;
      end
   end

   // payload: memories, queue entries, response data
   always_ff @(posedge clock) begin
      if (mem_we) begin
         reg_mem[ptr_idx] <= req_write_byte;
      end
      mem_rd_ff   <= reg_mem[ptr_idx_in];
      byp_data_ff <= req_write_byte;
      if (push) begin
         evt_ff[wr_slot_ff] <= {req_key_pressed, req_key_code};
      end
      rbyte_ff <= rbyte_in;
      irq_n_ff <= (count_in == '0);
      drop_ff  <= drop_in;
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_read_byte   = rbyte_ff;
   assign rsp_irq_n       = irq_n_ff;
   assign rsp_key_dropped = drop_ff;

endmodule
